### hdl/gbe_pkg.sv
// ----------------------------------------------------------------------------
// gbe_pkg
// Shared types and codes for the gap buffer text store.
// ----------------------------------------------------------------------------
package gbe_pkg;

  localparam int CAPACITY_DEF = 4096;

  localparam int TYPE_W  = 3;
  localparam int CHAR_W  = 8;
  localparam int POS_W   = 13;
  localparam int STAT_W  = 2;

  // request codes
  localparam logic [TYPE_W-1:0] REQ_INSERT   = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_MOVE     = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_DEL_FWD  = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_DEL_BACK = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_READ     = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [CHAR_W-1:0] char_in;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  count;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic [POS_W-1:0]  char_count;
    logic [POS_W-1:0]  gap_position;
    logic [STAT_W-1:0] status;
  } rsp_t;

endpackage

### hdl/gbe_ram.sv
// ----------------------------------------------------------------------------
// gbe_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/gap_buffer_editor_store.sv
// Steps after a request is taken: insert, delete, spare codes and out-of-range
//   requests finish in EXEC; a read goes through EXEC and READ_WAIT; a gap move
//   goes through EXEC and then a MOVE_RD, MOVE_WR pair per byte shifted (one RAM
//   read plus one RAM write per shifted byte). A held output parks the result in
//   RESULT. A new request is taken only once the block is back in IDLE.
// Reset (rst, synchronous): gap start 0, gap size CAPACITY, no result pending.
//   Text RAM contents are not cleared; only written bytes are ever read.
// ----------------------------------------------------------------------------
// gap_buffer_editor_store
// Fixed-capacity gap buffer: byte RAM plus gap start/size registers. Handles
// insert, gap move, forward/backward delete and read, one result per request.
// ----------------------------------------------------------------------------
module gap_buffer_editor_store #(
  parameter int CAPACITY = gbe_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  gbe_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output gbe_pkg::rsp_t rsp
);

  import gbe_pkg::*;

  // AW: RAM address bits, CW: gap register bits (must hold CAPACITY itself),
  // XW: common width for compares against 13-bit request fields.
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOVE_RD,
    S_MOVE_WR,
    S_READ_WAIT,
    S_RESULT
  } state_t;

  state_t state;

  // gap state
  logic [CW-1:0] gap_start, gap_size;
  logic [CW-1:0] gap_start_next, gap_size_next;

  // captured request
  logic [TYPE_W-1:0] rtype;
  logic [CHAR_W-1:0] rchar;
  logic [POS_W-1:0]  rpos;
  logic [POS_W-1:0]  rcnt;
  logic              mv_right;   // gap moves toward the end of the text

  // result payload under construction
  logic [CHAR_W-1:0] rd_char, rd_char_next;
  logic [STAT_W-1:0] status, status_next;

  // RAM port
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  // control
  logic   finish;     // result values are final this cycle
  logic   go_move;    // EXEC starts a gap shift
  logic   go_read;    // EXEC issued a text read
  logic   out_free;

  // extended views for arithmetic
  logic [XW-1:0] gs_x, gsz_x, pos_x, cnt_x, chars_x, cap_x;
  logic [XW:0]   fwd_sum;
  logic [XW:0]   fwd_size;
  logic [XW-1:0] tmp_addr;
  logic [XW-1:0] chars_next_x, gs_next_x;

  assign gs_x    = XW'(gap_start);
  assign gsz_x   = XW'(gap_size);
  assign pos_x   = XW'(rpos);
  assign cnt_x   = XW'(rcnt);
  assign cap_x   = XW'(CAPACITY);
  assign chars_x = cap_x - gsz_x;
  assign fwd_sum  = {1'b0, gs_x} + {1'b0, gsz_x} + {1'b0, cnt_x};
  assign fwd_size = {1'b0, gsz_x} + {1'b0, cnt_x};

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    gap_start_next = gap_start;
    gap_size_next  = gap_size;
    rd_char_next   = rd_char;
    status_next    = status;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = gap_start[AW-1:0];
    ram_raddr      = gap_start[AW-1:0];
    ram_wdata      = rchar;
    tmp_addr       = gs_x;
    finish         = 1'b0;
    go_move        = 1'b0;
    go_read        = 1'b0;
    case (state)
      S_EXEC: begin
        rd_char_next = '0;
        status_next  = ST_OK;
        finish       = 1'b1;
        case (rtype)
          REQ_INSERT: begin
            if (gap_size == '0) begin
              status_next = ST_FULL;
            end else begin
              ram_we         = 1'b1;
              ram_waddr      = gap_start[AW-1:0];
              ram_wdata      = rchar;
              gap_start_next = gap_start + CW'(1);
              gap_size_next  = gap_size - CW'(1);
            end
          end
          REQ_MOVE: begin
            if (pos_x > chars_x) begin
              status_next = ST_RANGE;
            end else if (pos_x != gs_x) begin
              finish  = 1'b0;
              go_move = 1'b1;
            end
          end
          REQ_DEL_FWD: begin
            if (fwd_sum <= {1'b0, cap_x}) begin
              gap_size_next = fwd_size[CW-1:0];
            end else begin
              gap_size_next = CW'(cap_x - gs_x);
            end
          end
          REQ_DEL_BACK: begin
            if (cnt_x <= gs_x) begin
              gap_start_next = CW'(gs_x - cnt_x);
              gap_size_next  = fwd_size[CW-1:0];
            end else begin
              gap_start_next = '0;
              gap_size_next  = gap_size + gap_start;
            end
          end
          REQ_READ: begin
            if (pos_x >= chars_x) begin
              status_next = ST_RANGE;
            end else begin
              finish    = 1'b0;
              go_read   = 1'b1;
              ram_re    = 1'b1;
              tmp_addr  = (pos_x < gs_x) ? pos_x : pos_x + gsz_x;
              ram_raddr = tmp_addr[AW-1:0];
            end
          end
          default: begin
            // unused request type: no state change, ok status
          end
        endcase
      end
      S_MOVE_RD: begin
        ram_re    = 1'b1;
        tmp_addr  = mv_right ? gs_x + gsz_x : gs_x - XW'(1);
        ram_raddr = tmp_addr[AW-1:0];
      end
      S_MOVE_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        tmp_addr  = mv_right ? gs_x : gs_x + gsz_x - XW'(1);
        ram_waddr = tmp_addr[AW-1:0];
        gap_start_next = mv_right ? gap_start + CW'(1) : gap_start - CW'(1);
        finish    = (XW'(gap_start_next) == pos_x);
      end
      S_READ_WAIT: begin
        rd_char_next = ram_rdata;
        finish       = 1'b1;
      end
      S_RESULT: begin
        finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign chars_next_x = cap_x - XW'(gap_size_next);
  assign gs_next_x    = XW'(gap_start_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gap_start <= '0;
      gap_size  <= CW'(CAPACITY);
      rsp_valid <= 1'b0;
    end else begin
      gap_start <= gap_start_next;
      gap_size  <= gap_size_next;
      rd_char   <= rd_char_next;
      status    <= status_next;
      // a new result replaces the one taken this cycle
      if (finish && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            rtype <= req.req_type;
            rchar <= req.char_in;
            rpos  <= req.position;
            rcnt  <= req.count;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          mv_right <= (pos_x > gs_x);
          if (go_move) begin
            state <= S_MOVE_RD;
          end else if (go_read) begin
            state <= S_READ_WAIT;
          end
        end
        S_MOVE_RD: begin
          state <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          if (!finish) begin
            state <= S_MOVE_RD;
          end
        end
        default: begin
        end
      endcase
      // finished transactions go straight to the output register when free
      if (finish) begin
        if (out_free) begin
          rsp.read_char     <= rd_char_next;
          rsp.char_count    <= chars_next_x[POS_W-1:0];
          rsp.gap_position  <= gs_next_x[POS_W-1:0];
          rsp.status        <= status_next;
          state             <= S_IDLE;
        end else begin
          state <= S_RESULT;
        end
      end
    end
  end

  gbe_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(CAPACITY)
  ) u_text_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // gap never runs past the end of the buffer
  a_gap_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, gs_x} + {1'b0, gsz_x}) <= {1'b0, cap_x})
    else $error("gap extends past buffer end");

  // RAM writes only for an insert or a shift step
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_EXEC || state == S_MOVE_WR))
    else $error("unexpected text RAM write");

  // an accepted request always starts execution next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_EXEC))
    else $error("accepted request not executed");

  // a shift write always follows its read
  a_move_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE_RD) |=> (state == S_MOVE_WR))
    else $error("shift read not followed by write");

endmodule

### tb/tb_gap_buffer_editor_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gap_buffer_editor_store
// Self-checking bench for the gap buffer text store. A queue of requests feeds
// a valid/stall driver. Each accepted transaction runs through a bench-side
// copy of the buffer. A monitor checks every returned result, in order,
// against the oldest prediction. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_gap_buffer_editor_store;
  import gbe_pkg::*;

  localparam int CAP           = CAPACITY_DEF;
  localparam int POS_MAX       = (1 << POS_W) - 1;  // all ones in a 13-bit field
  localparam int RAND_PER_SEG  = 230;                // random requests per phase
  localparam int NUM_SEGS      = 8;
  localparam int HOLD_CYCLES   = 400;                // long receiver hold-off
  localparam int TEXT_SOFT_MAX = 300;                // keeps random gap moves short
  localparam int DRAIN_CYCLES  = 20;

  // Request codes the block ignores. They are the values above the read code.
  localparam logic [TYPE_W-1:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_SPARE_LAST  = 3'd7;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic rsp_hold  = 1'b0;

  // Requests that are waiting to be sent, and results that are still due.
  req_t pending_reqs[$];
  rsp_t pending_results[$];
  rsp_t want_rsp;

  // Bench copy of the buffer. It is updated only when a transaction is accepted.
  bit [CHAR_W-1:0] text_copy [CAP];
  int unsigned     gap_lo  = 0;
  int unsigned     gap_len = CAP;

  // The generator tracks text length and gap position on its own, so it can
  // aim gap moves and reads at real text ahead of acceptance.
  int gen_len = 0;
  int gen_gap = 0;

  int     send_idle_pct = 0;
  int     stall_pct     = 0;
  longint cycle_budget  = 0;
  longint cycle_cnt     = 0;

  int err_cnt    = 0;
  int result_cnt = 0;
  int full_seen  = 0;
  int range_seen = 0;
  int peak_chars = 0;
  int kind_seen [8];

  gap_buffer_editor_store #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Applies one request to the bench copy and returns the result it must give.
  // Gap moves shift one byte at a time, the same way the buffer itself does.
  function automatic rsp_t apply_edit(req_t r);
    rsp_t        res;
    int unsigned chars;
    int unsigned pos;
    int unsigned cnt;
    res        = '0;
    res.status = ST_OK;
    chars      = CAP - gap_len;
    pos        = r.position;
    cnt        = r.count;
    case (r.req_type)
      REQ_INSERT: begin
        if (gap_len == 0) begin
          res.status = ST_FULL;               // full: the byte is dropped
        end else begin
          text_copy[gap_lo] = r.char_in;
          gap_lo++;
          gap_len--;
        end
      end
      REQ_MOVE: begin
        if (pos > chars) begin
          res.status = ST_RANGE;
        end else begin
          while (gap_lo < pos) begin
            text_copy[gap_lo] = text_copy[gap_lo + gap_len];
            gap_lo++;
          end
          while (gap_lo > pos) begin
            text_copy[gap_lo + gap_len - 1] = text_copy[gap_lo - 1];
            gap_lo--;
          end
        end
      end
      REQ_DEL_FWD: begin
        // Past the end of the text the gap is clamped to the top of the store.
        if (gap_lo + gap_len + cnt <= CAP) gap_len += cnt;
        else gap_len = CAP - gap_lo;
      end
      REQ_DEL_BACK: begin
        // Past the start of the text the gap start is clamped to zero.
        if (cnt <= gap_lo) begin
          gap_lo  -= cnt;
          gap_len += cnt;
        end else begin
          gap_len += gap_lo;
          gap_lo   = 0;
        end
      end
      REQ_READ: begin
        if (pos >= chars) res.status = ST_RANGE;
        else if (pos < gap_lo) res.read_char = text_copy[pos];
        else res.read_char = text_copy[pos + gap_len];
      end
      default: ;                              // spare codes change nothing
    endcase
    res.char_count   = POS_W'(CAP - gap_len);
    res.gap_position = POS_W'(gap_lo);
    if (int'(CAP - gap_len) > peak_chars) peak_chars = CAP - gap_len;
    return res;
  endfunction

  // Queues one request, updates the generator's view of the text and adds to
  // the cycle budget, more for a gap move the more bytes it shifts.
  function automatic void queue_request(logic [TYPE_W-1:0] kind, int ch, int pos, int cnt);
    req_t r;
    int   moved;
    int   del;
    r.req_type = kind;
    r.char_in  = CHAR_W'(ch);
    r.position = POS_W'(pos);
    r.count    = POS_W'(cnt);
    pending_reqs.push_back(r);
    moved = 0;
    case (kind)
      REQ_INSERT: begin
        if (gen_len < CAP) begin
          gen_len++;
          gen_gap++;
        end
      end
      REQ_MOVE: begin
        if (pos <= gen_len) begin
          moved   = (pos > gen_gap) ? pos - gen_gap : gen_gap - pos;
          gen_gap = pos;
        end
      end
      REQ_DEL_FWD: begin
        del      = (cnt < gen_len - gen_gap) ? cnt : gen_len - gen_gap;
        gen_len -= del;
      end
      REQ_DEL_BACK: begin
        del      = (cnt < gen_gap) ? cnt : gen_gap;
        gen_gap -= del;
        gen_len -= del;
      end
      default: ;
    endcase
    cycle_budget += 40 + 2 * moved;
  endfunction

  // Driver: the prediction is made at the edge where a transaction is taken.
  // A new request is then offered, or valid drops to idle.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        pending_results.push_back(apply_edit(req));
        kind_seen[req.req_type]++;
      end
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req       <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random by phase, forced high during a hold-off.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= rsp_hold || ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: each result taken is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("unexpected result: char %02h count %0d gap %0d status %0d",
                   rsp.read_char, rsp.char_count, rsp.gap_position, rsp.status);
        end
      end else begin
        want_rsp = pending_results.pop_front();
        result_cnt++;
        if (rsp.read_char !== want_rsp.read_char || rsp.char_count !== want_rsp.char_count ||
            rsp.gap_position !== want_rsp.gap_position || rsp.status !== want_rsp.status) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("result %0d mismatch: char %02h/%02h count %0d/%0d gap %0d/%0d status %0d/%0d (exp/got)",
                     result_cnt, want_rsp.read_char, rsp.read_char, want_rsp.char_count,
                     rsp.char_count, want_rsp.gap_position, rsp.gap_position,
                     want_rsp.status, rsp.status);
          end
        end
        if (rsp.status == ST_FULL) full_seen++;
        if (rsp.status == ST_RANGE) range_seen++;
      end
    end
  end

  // Watchdog: the limit grows with the work queued, with a wide margin.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 50000 + 5 * cycle_budget) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_cnt,
               pending_results.size());
      $display("tb_gap_buffer_editor_store NOT OK");
      $finish;
    end
  end

  initial begin
    int pick;
    int ch;
    int pos;
    int cnt;
    int lo;
    int hi;

    // Directed requests. On an empty store, a read is out of range, a move to
    // zero is fine, a move to one is out of range, and deletes do nothing.
    queue_request(REQ_READ, 0, 0, 0);
    queue_request(REQ_MOVE, 0, 0, 0);
    queue_request(REQ_MOVE, 0, 1, 0);
    queue_request(REQ_DEL_FWD, 0, 0, 0);
    queue_request(REQ_DEL_BACK, 0, 0, POS_MAX);
    // Byte extremes and alternating bit patterns.
    queue_request(REQ_INSERT, 8'h00, 0, 0);
    queue_request(REQ_INSERT, 8'hFF, 0, 0);
    queue_request(REQ_INSERT, 8'hA5, 0, 0);
    queue_request(REQ_INSERT, 8'h5A, 0, 0);
    // Read the first and last bytes, one past the end, and the largest position.
    queue_request(REQ_READ, 0, 0, 0);
    queue_request(REQ_READ, 0, 3, 0);
    queue_request(REQ_READ, 0, 4, 0);
    queue_request(REQ_READ, 0, POS_MAX, 0);
    // Move the gap back into the text. Read on both sides of it.
    queue_request(REQ_MOVE, 0, 1, 0);
    queue_request(REQ_READ, 0, 0, 0);
    queue_request(REQ_READ, 0, 1, 0);
    queue_request(REQ_READ, 0, 3, 0);
    queue_request(REQ_MOVE, 0, 4, 0);
    // Deletes that run off the end clamp at the buffer edges.
    queue_request(REQ_MOVE, 0, 2, 0);
    queue_request(REQ_DEL_FWD, 0, 0, POS_MAX);
    queue_request(REQ_DEL_BACK, 0, 0, 1);
    queue_request(REQ_DEL_BACK, 0, 0, CAP);
    for (int k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++) begin
      queue_request(TYPE_W'(k), 8'hFF, POS_MAX, POS_MAX);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Phases cycle through no idling, sender idle, receiver stalling, and both.
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      send_idle_pct = (seg % 4 == 1) ? 79 : (seg % 4 == 3) ? 14 : 0;
      stall_pct     = (seg % 4 == 2) ? 79 : (seg % 4 == 3) ? 14 : 0;
      for (int n = 0; n < RAND_PER_SEG; n++) begin
        // Fields that the request type does not use stay random. The block
        // must ignore them.
        pick = $urandom_range(99);
        ch   = $urandom_range(255);
        pos  = $urandom_range(POS_MAX);
        cnt  = $urandom_range(POS_MAX);
        if (pick < 35) begin
          // While the text is long, this slot trims it instead of inserting.
          if (gen_len < TEXT_SOFT_MAX) queue_request(REQ_INSERT, ch, pos, cnt);
          else queue_request(REQ_DEL_BACK, ch, pos, $urandom_range(64));
        end else if (pick < 50) begin
          // Mostly short moves near the gap, some anywhere, some past the end.
          pick = $urandom_range(9);
          if (pick < 8) begin
            lo  = (gen_gap > 16) ? gen_gap - 16 : 0;
            hi  = (gen_gap + 16 < gen_len) ? gen_gap + 16 : gen_len;
            pos = $urandom_range(hi, lo);
          end else if (pick == 8) begin
            pos = $urandom_range(gen_len, 0);
          end else if (gen_len < POS_MAX) begin
            pos = $urandom_range(POS_MAX, gen_len + 1);
          end
          queue_request(REQ_MOVE, ch, pos, cnt);
        end else if (pick < 74) begin
          if ($urandom_range(99) < 85) cnt = $urandom_range(8);
          queue_request((pick < 62) ? REQ_DEL_FWD : REQ_DEL_BACK, ch, pos, cnt);
        end else if (pick < 95) begin
          if (gen_len > 0 && $urandom_range(99) < 85) pos = $urandom_range(gen_len - 1, 0);
          queue_request(REQ_READ, ch, pos, cnt);
        end else begin
          queue_request(TYPE_W'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST)), ch, pos, cnt);
        end
      end

      // The receiver holds off for a long stretch while the sender keeps
      // offering. The block should fill and then stall its input.
      if (seg == 4) begin
        cycle_budget += HOLD_CYCLES;
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
      end
      while (pending_reqs.size() != 0) @(posedge clk);

      // Fill the store, then check the full case, moves across the whole
      // text, reads at the top edge, and clamped deletes that empty it again.
      if (seg == 3) begin
        send_idle_pct = 0;
        stall_pct     = 0;
        while (gen_len < CAP) queue_request(REQ_INSERT, $urandom_range(255), 0, 0);
        queue_request(REQ_INSERT, 8'h3C, 0, 0);
        queue_request(REQ_INSERT, 8'hC3, POS_MAX, POS_MAX);
        queue_request(REQ_READ, 0, CAP - 1, 0);
        queue_request(REQ_READ, 0, CAP, 0);
        queue_request(REQ_MOVE, 0, 0, 0);
        queue_request(REQ_READ, 0, 0, 0);
        queue_request(REQ_READ, 0, CAP - 1, 0);
        queue_request(REQ_MOVE, 0, CAP, 0);
        queue_request(REQ_DEL_FWD, 0, 0, 1);
        queue_request(REQ_INSERT, 8'h81, 0, 0);
        queue_request(REQ_MOVE, 0, CAP / 2, 0);
        queue_request(REQ_READ, 0, CAP / 2, 0);
        queue_request(REQ_DEL_FWD, 0, 0, POS_MAX);
        queue_request(REQ_DEL_BACK, 0, 0, POS_MAX);
        while (pending_reqs.size() != 0) @(posedge clk);
      end
    end

    // Drain: nothing left to send, nothing in flight, then a short tail.
    while (pending_reqs.size() != 0 || req_valid || pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    err_cnt += pending_results.size();

    $display("checked %0d results: %0d inserts, %0d moves, %0d deletes, %0d reads, %0d spare",
             result_cnt, kind_seen[REQ_INSERT], kind_seen[REQ_MOVE],
             kind_seen[REQ_DEL_FWD] + kind_seen[REQ_DEL_BACK], kind_seen[REQ_READ],
             kind_seen[REQ_SPARE_FIRST] + kind_seen[REQ_SPARE_FIRST + 1] +
             kind_seen[REQ_SPARE_LAST]);
    $display("full drops %0d, out-of-range %0d, peak text %0d bytes, %0d failures",
             full_seen, range_seen, peak_chars, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_gap_buffer_editor_store OK");
    end else begin
      $display("tb_gap_buffer_editor_store NOT OK");
    end
    $finish;
  end

endmodule
